// File: design/kdr_pkg.sv
// ---------------------------------------------------------------------------
// kdr_pkg
// Types and constants for the keypad scanner with debounce and auto-repeat.
// ---------------------------------------------------------------------------
package kdr_pkg;

  localparam int ROWS_DEFAULT = 4;

  // Register reset values
  localparam logic [7:0] DEBOUNCE_COUNT_RST  = 8'd5;
  localparam logic [7:0] REPEAT_FIRST_RST    = 8'd100;
  localparam logic [7:0] REPEAT_INTERVAL_RST = 8'd70;
  localparam logic [3:0] REPEAT_KEY_MASK_RST = 4'h6;

  localparam int CFG_INDEX_W = 8;
  localparam int CFG_DATA_W  = 8;

  // Register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_DEBOUNCE_COUNT  = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_REPEAT_FIRST    = 8'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_REPEAT_INTERVAL = 8'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_REPEAT_KEY_MASK = 8'd3;

  typedef struct packed {
    logic sense_low;
    logic set_mode;
  } tick_t;

  typedef struct packed {
    logic [3:0] row_drive;
    logic       key_event;
    logic [2:0] key_index;
  } result_t;

endpackage

// File: design/keypad_scan_debounce_repeat_top.sv
// The result of an accepted tick is in the output register in the next cycle.
// Throughput: one tick per cycle; a tick is taken while the previous result
// waits, as long as the output register is empty or being emptied.
// Reset (rst, synchronous): row 0, no key accepted or pending, counters and
// registers at their default values, output register empty.
// ---------------------------------------------------------------------------
// keypad_scan_debounce_repeat_top
// Row scanner with debounce of key changes and auto-repeat in setting mode.
// ---------------------------------------------------------------------------
module keypad_scan_debounce_repeat_top
  import kdr_pkg::*;
#(
  parameter int ROWS = ROWS_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   tick_valid,
  output logic                   tick_ready,
  input  tick_t                  tick,
  output logic                   result_valid,
  input  logic                   result_ready,
  output result_t                result,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int SW = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int KW = $clog2(ROWS + 1);
  localparam logic [KW-1:0] NO_KEY   = KW'(ROWS);
  localparam logic [SW-1:0] LAST_ROW = SW'(ROWS - 1);

  logic [7:0] debounce_count;
  logic [7:0] repeat_first;
  logic [7:0] repeat_interval;
  logic [3:0] repeat_key_mask;

  logic [SW-1:0] scan_row, scan_row_next;
  logic [KW-1:0] accepted_key, accepted_key_next;
  logic [KW-1:0] candidate_key, candidate_key_next;
  logic [7:0]    debounce_left, debounce_left_next;
  logic [7:0]    repeat_left, repeat_left_next;
  logic          event_next;
  logic [KW-1:0] code;
  logic [3:0]    key_wide;
  logic          repeat_on;
  logic [7:0]    debounce_dec;
  logic [7:0]    repeat_dec;
  logic [SW-1:0] scan_row_adv;
  logic [3:0]    drive_next;
  logic [2:0]    row_low;
  logic          tick_take;

  assign tick_ready = !result_valid || result_ready;
  assign tick_take  = tick_valid && tick_ready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_count  <= DEBOUNCE_COUNT_RST;
      repeat_first    <= REPEAT_FIRST_RST;
      repeat_interval <= REPEAT_INTERVAL_RST;
      repeat_key_mask <= REPEAT_KEY_MASK_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DEBOUNCE_COUNT:  debounce_count  <= cfg_data;
        REG_REPEAT_FIRST:    repeat_first    <= cfg_data;
        REG_REPEAT_INTERVAL: repeat_interval <= cfg_data;
        REG_REPEAT_KEY_MASK: repeat_key_mask <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  assign code         = tick.sense_low ? KW'(scan_row) : NO_KEY;
  assign key_wide     = 4'(accepted_key);
  assign repeat_on    = tick.set_mode && (key_wide < 4'd4) &&
                        repeat_key_mask[key_wide[1:0]];
  assign debounce_dec = debounce_left - 8'd1;
  assign repeat_dec   = repeat_left - 8'd1;
  assign scan_row_adv = (scan_row == LAST_ROW) ? '0 : scan_row + SW'(1);

  always_comb begin
    scan_row_next      = scan_row;
    accepted_key_next  = accepted_key;
    candidate_key_next = candidate_key;
    debounce_left_next = debounce_left;
    repeat_left_next   = repeat_left;
    event_next         = 1'b0;
    if (code == accepted_key) begin
      if (accepted_key == NO_KEY) begin
        scan_row_next = scan_row_adv;
      end else if (repeat_on) begin
        repeat_left_next = repeat_dec;
        if (repeat_dec == 8'd0) begin
          repeat_left_next = repeat_interval;
          event_next       = 1'b1;
        end
      end
    end else if (code == candidate_key) begin
      debounce_left_next = debounce_dec;
      if (debounce_dec == 8'd0) begin
        accepted_key_next = code;
        if (code == NO_KEY) begin
          scan_row_next = scan_row_adv;
        end else begin
          event_next = 1'b1;
        end
      end
    end else begin
      // new code: restart both counts
      candidate_key_next = code;
      debounce_left_next = debounce_count;
      repeat_left_next   = repeat_first;
    end
  end

  // Active-low drive; rows beyond the four pins drive nothing
  always_comb begin
    row_low = 3'(scan_row_next);
    for (int i = 0; i < 4; i++) begin
      drive_next[i] = (row_low != 3'(i));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_row      <= '0;
      accepted_key  <= NO_KEY;
      candidate_key <= NO_KEY;
      debounce_left <= DEBOUNCE_COUNT_RST;
      repeat_left   <= REPEAT_FIRST_RST;
    end else if (tick_take) begin
      scan_row      <= scan_row_next;
      accepted_key  <= accepted_key_next;
      candidate_key <= candidate_key_next;
      debounce_left <= debounce_left_next;
      repeat_left   <= repeat_left_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (tick_take) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tick_take) begin
      result.row_drive <= drive_next;
      result.key_event <= event_next;
      result.key_index <= 3'(accepted_key_next);
    end
  end

endmodule

// File: sim/keypad_scan_debounce_repeat_top_test.sv
// ---------------------------------------------------------------------------
// keypad_scan_debounce_repeat_top_test
// Drives scan ticks into the keypad scanner and checks every result against
// a cycle-free model of row scanning, debounce and auto-repeat. Runs directed
// key sequences, counters loaded with zero, extreme register values, random
// press and release sequences under several idle and stall mixes, and a long
// receiver hold-off that backs the block up.
// ---------------------------------------------------------------------------
module keypad_scan_debounce_repeat_top_test
  import kdr_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int          NUM_ROWS     = ROWS_DEFAULT;
  localparam logic [2:0]  NO_KEY       = 3'(NUM_ROWS);
  localparam int unsigned CYCLE_LIMIT  = 200000;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   tick_valid = 1'b0;
  logic                   tick_ready;
  tick_t                  tick = '0;
  logic                   result_valid;
  logic                   result_ready = 1'b0;
  result_t                result;
  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  keypad_scan_debounce_repeat_top i_dut (
    .clk          (clk),
    .rst          (rst),
    .tick_valid   (tick_valid),
    .tick_ready   (tick_ready),
    .tick         (tick),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // Scanner model: configuration
  logic [7:0] settle_ticks = DEBOUNCE_COUNT_RST;
  logic [7:0] first_delay  = REPEAT_FIRST_RST;
  logic [7:0] rep_period   = REPEAT_INTERVAL_RST;
  logic [3:0] rep_enable   = REPEAT_KEY_MASK_RST;

  // Scanner model: state
  logic [1:0] cur_row     = '0;
  logic [2:0] held_key    = NO_KEY;
  logic [2:0] cand_key    = NO_KEY;
  logic [7:0] settle_cnt  = DEBOUNCE_COUNT_RST;
  logic [7:0] autorep_cnt = REPEAT_FIRST_RST;

  result_t     pending_results[$];
  int          idle_pct      = 0;
  int          stall_pct     = 0;
  int          hold_request  = 0;
  int          ticks_sent    = 0;
  int          results_seen  = 0;
  int          mismatches    = 0;
  int unsigned cycle_count   = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic void next_row();
    cur_row = (cur_row == 2'(NUM_ROWS - 1)) ? 2'd0 : cur_row + 2'd1;
  endfunction

  // Advance the scanner model by one tick and return the result it produces.
  function automatic result_t scan_tick_outcome(tick_t t);
    logic [2:0] code;
    logic       fired;
    result_t    r;
    code  = t.sense_low ? {1'b0, cur_row} : NO_KEY;
    fired = 1'b0;
    if (code == held_key) begin
      if (held_key == NO_KEY) begin
        next_row();
      end else if (t.set_mode && held_key < 3'd4 && rep_enable[held_key[1:0]]) begin
        autorep_cnt = autorep_cnt - 8'd1;
        if (autorep_cnt == 8'd0) begin
          autorep_cnt = rep_period;
          fired       = 1'b1;
        end
      end
    end else if (code == cand_key) begin
      settle_cnt = settle_cnt - 8'd1;
      if (settle_cnt == 8'd0) begin
        held_key = code;
        if (code == NO_KEY) next_row();
        else fired = 1'b1;
      end
    end else begin
      // a fresh code restarts both counters
      cand_key    = code;
      settle_cnt  = settle_ticks;
      autorep_cnt = first_delay;
    end
    r.row_drive = ~(4'b0001 << cur_row);
    r.key_event = fired;
    r.key_index = held_key;
    return r;
  endfunction

  // Offer one tick after a random gap, hold it until taken, then predict.
  task automatic send_tick(input tick_t t);
    int gap;
    gap = 0;
    while (gap < 20 && $urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      tick_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    tick_valid <= 1'b1;
    tick       <= t;
    do @(posedge clk); while (!tick_ready);
    pending_results.push_back(scan_tick_outcome(t));
    ticks_sent++;
  endtask

  task automatic send_run(input int n, input logic sense, input logic mode);
    tick_t t;
    t.sense_low = sense;
    t.set_mode  = mode;
    repeat (n) send_tick(t);
  endtask

  // Drop valid and wait until every expected result has come back.
  task automatic wait_drained();
    tick_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // Write all four registers plus one random index past the end, which must be ignored.
  task automatic program_regs(input logic [7:0] deb, input logic [7:0] first,
                              input logic [7:0] period, input logic [3:0] mask);
    cfg_we    <= 1'b1;
    cfg_index <= REG_DEBOUNCE_COUNT;
    cfg_data  <= deb;
    @(posedge clk);
    settle_ticks = deb;
    cfg_index <= REG_REPEAT_FIRST;
    cfg_data  <= first;
    @(posedge clk);
    first_delay = first;
    cfg_index <= REG_REPEAT_INTERVAL;
    cfg_data  <= period;
    @(posedge clk);
    rep_period = period;
    cfg_index <= REG_REPEAT_KEY_MASK;
    cfg_data  <= {4'($urandom_range(15)), mask};
    @(posedge clk);
    rep_enable = mask;
    cfg_index <= REG_REPEAT_KEY_MASK + 8'd1 + 8'($urandom_range(251));
    cfg_data  <= 8'($urandom_range(255));
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Mostly well-formed press/release sequences, with some bounce and noise.
  task automatic run_key_sequences(input int n_ticks);
    int    sent, hold_max, gap_max, hold_len, gap_len, i;
    logic  mode, bouncy;
    tick_t t;
    sent = 0;
    while (sent < n_ticks) begin
      if ($urandom_range(9) == 0) begin
        repeat (4) begin
          t = tick_t'(2'($urandom_range(3)));
          send_tick(t);
          sent++;
        end
      end else begin
        hold_max = int'(settle_ticks) + int'(first_delay) + 2 * int'(rep_period) + 2;
        if (hold_max > 40) hold_max = 40;
        gap_max = int'(settle_ticks) + 3;
        if (gap_max > 12) gap_max = 12;
        hold_len = $urandom_range(hold_max);
        gap_len  = $urandom_range(gap_max);
        // keep within the requested number of ticks
        if (hold_len > n_ticks - sent) hold_len = n_ticks - sent;
        if (gap_len > n_ticks - sent - hold_len) gap_len = n_ticks - sent - hold_len;
        mode     = 1'($urandom_range(1));
        bouncy   = ($urandom_range(6) == 0);
        for (i = 0; i < hold_len; i++) begin
          t.sense_low = bouncy ? 1'($urandom_range(1)) : 1'b1;
          t.set_mode  = ($urandom_range(19) == 0) ? ~mode : mode;
          send_tick(t);
        end
        for (i = 0; i < gap_len; i++) begin
          t.sense_low = 1'b0;
          t.set_mode  = mode;
          send_tick(t);
        end
        sent += hold_len + gap_len;
      end
    end
  endtask

  task automatic test_reset_defaults();
    // release twice to step the scan, then hold long enough for five-tick debounce
    send_run(2, 1'b0, 1'b0);
    send_run(6, 1'b1, 1'b1);
    wait_drained();
  endtask

  task automatic test_directed_keys();
    program_regs(8'd1, 8'd2, 8'd1, 4'hF);
    // key still held: its repeat counter keeps the load from before the write
    send_run(3, 1'b1, 1'b1);
    send_run(2, 1'b0, 1'b0);
    send_run(5, 1'b1, 1'b1);
    send_run(1, 1'b1, 1'b0);
    send_run(1, 1'b0, 1'b1);
    send_run(1, 1'b1, 1'b1);
    send_run(3, 1'b0, 1'b0);
    wait_drained();
  endtask

  task automatic test_zero_counts();
    // zero loads count down through the wrap: 256 ticks each
    program_regs(8'd0, 8'd0, 8'd255, 4'hF);
    send_run(515, 1'b1, 1'b1);
    wait_drained();
    program_regs(8'd1, 8'd3, 8'd2, 4'hF);
    send_run(3, 1'b0, 1'b0);
    wait_drained();
  endtask

  task automatic test_max_counts();
    program_regs(8'd255, 8'd255, 8'd255, 4'h0);
    run_key_sequences(10);
    wait_drained();
  endtask

  task automatic test_random_phase(input int idle, input int stall, input int n_ticks);
    program_regs(8'($urandom_range(1, 4)), 8'($urandom_range(1, 12)),
                 8'($urandom_range(1, 6)), 4'($urandom_range(15)));
    idle_pct  = idle;
    stall_pct = stall;
    run_key_sequences(n_ticks);
    wait_drained();
  endtask

  task automatic test_backpressure();
    idle_pct     = 0;
    stall_pct    = 0;
    hold_request = 40;
    run_key_sequences(45);
    wait_drained();
  endtask

  // Receiver: random stalls, plus a long hold-off on request.
  initial begin : receiver
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_request > 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        result_ready <= 1'b0;
        hold_left--;
      end else begin
        result_ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  always @(posedge clk) begin : result_check
    result_t want;
    if (!rst && result_valid && result_ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("result with nothing expected: %h", result);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (result.row_drive !== want.row_drive) begin
          $error("row_drive: expected %h, got %h", want.row_drive, result.row_drive);
          mismatches++;
        end
        if (result.key_event !== want.key_event) begin
          $error("key_event: expected %b, got %b", want.key_event, result.key_event);
          mismatches++;
        end
        if (result.key_index !== want.key_index) begin
          $error("key_index: expected %0d, got %0d", want.key_index, result.key_index);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, pending_results.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_directed_keys();
    test_zero_counts();
    test_max_counts();
    test_random_phase(0, 0, 15);
    test_random_phase(68, 0, 15);
    test_random_phase(0, 68, 15);
    test_random_phase(32, 32, 15);
    test_backpressure();
    wait_drained();
    repeat (4) @(posedge clk);
    $display("covered: reset defaults, directed keys, zero and maximum counts,");
    $display("random sequences under four idle mixes, hold-off; %0d ticks, %0d results",
             ticks_sent, results_seen);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// File: keypad_scan_debounce_repeat_top.f
design/kdr_pkg.sv
design/keypad_scan_debounce_repeat_top.sv
sim/keypad_scan_debounce_repeat_top_test.sv
